>>> hw/rtl/kftl_pkg.sv
// Package with shared types, constants and command structs for the keyframe time locator.
package kftl_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int TW = 32;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_RATE  = 2'd1;
    localparam logic [1:0] REG_LOOP  = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         key_slot;
        logic signed [31:0] key_time;
        logic signed [31:0] global_time;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         span_index;
        logic [16:0]        interpolant;
        logic signed [31:0] local_time;
        logic               error;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input item, start reading key 0
        logic rd_last;    // issue read of last key
        logic cap_first;  // capture first key
        logic cap_last;   // capture last key, compute duration
        logic mul;        // register product
        logic scale;      // compute local time
        logic div_start;  // start a division
        logic div_step;   // one restoring division step
        logic wrap_done;  // take remainder as local time, clamp range
        logic srch_rd;    // read key k+1
        logic srch_cmp;   // compare t with key k+1
        logic span_rd;    // read key k
        logic span_cap;   // latch simple interpolant, set up interpolant divide
        logic frac_done;  // finalize interpolant
        logic err_out;    // produce error result
        logic wr_out;     // produce zero result of write item
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic n_small;
        logic dur_bad;
        logic need_wrap;
        logic srch_more;
        logic frac_simple;
        logic div_last;
    } stat_t;

endpackage

>>> hw/rtl/keyframe_time_locate.sv
// Top level of the keyframe time locator.
// The block keeps a table of keyframe times and answers two kinds of input beats.
// A write beat (opcode 0) stores key_time into the slot key_slot and returns a
// beat with all fields zero. A sample beat (opcode 1) turns global_time into a
// local time, wraps or clamps it by the duration, clamps it into the key range,
// searches the spans in order and returns the span index and its interpolant.
// Both channels use valid and ready; the result sits in an output register, so
// a stalled receiver holds the result and the block waits before its next beat.
// Configuration writes take effect at once; the user must issue them only while
// idle, as the block itself does not enforce it. The span is found by a linear
// search through the single key memory read port; a bit-serial divider wraps
// the local time when looping wraps, and divides for the interpolant when the
// span needs a division.
// Reset clears the registers to their reset values and the output to empty;
// the key table holds nothing defined until it is written.
module keyframe_time_locate #(
    parameter int MAX_KEYS = kftl_pkg::MAX_KEYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kftl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kftl_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import kftl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer that steps the datapath through one beat.
    kftl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Key memory, arithmetic and the result register.
    kftl_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .res       (out_data)
    );
endmodule

>>> hw/rtl/kftl_datapath.sv
// Datapath of the keyframe time locator: key memory, scaling, divider and search.
module kftl_datapath #(
    parameter int MAX_KEYS = kftl_pkg::MAX_KEYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kftl_pkg::in_item_t  in_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  kftl_pkg::cmd_t      cmd,
    output kftl_pkg::stat_t     stat,
    output kftl_pkg::out_item_t res
);
    import kftl_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic signed [31:0] start_reg, rate_reg;
    logic               loop_reg;
    logic [6:0]         count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            rate_reg  <= 32'sd65536;
            loop_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START: start_reg <= cfg_data;
                REG_RATE:  rate_reg  <= cfg_data;
                REG_LOOP:  loop_reg  <= cfg_data[0];
                REG_COUNT: count_reg <= cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    logic signed [31:0] mem [MAX_KEYS];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;

    in_item_t           item_reg;
    logic [CW-1:0]      n_reg;
    logic [AW-1:0]      k_reg;
    logic signed [31:0] first_reg, last_reg, kv_reg;
    logic signed [32:0] dur_reg;
    logic signed [32:0] diff_reg;
    logic signed [65:0] prod_reg;
    logic signed [49:0] local_reg;
    logic signed [32:0] t_reg;
    logic [49:0]        quo_reg;
    logic [33:0]        rem_reg;
    logic [33:0]        den_reg;
    logic [5:0]         cnt_reg;
    logic               div_frac_reg;
    logic               kv_cap_reg;
    logic               simple_hold_reg;
    out_item_t          res_reg;

    logic [7:0] cnt_ext;

    // Effective key count clamped to the table.
    logic [6:0] n_eff;
    always_comb
    begin
        if (32'(count_reg) > MAX_KEYS)
            n_eff = 7'(MAX_KEYS);
        else
            n_eff = count_reg;
    end

    always_comb
    begin
        rd_en = 1'b1;
        rd_addr = '0;
        if (cmd.rd_last)
            rd_addr = AW'(n_reg - CW'(1));
        else if (cmd.srch_rd)
            rd_addr = k_reg + AW'(1);
        else if (cmd.span_rd)
            rd_addr = k_reg;
        else if (!cmd.load)
            rd_en = 1'b0;
    end

    // A write beat stores its key while the controller decodes it.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_out && 32'(item_reg.key_slot) < MAX_KEYS)
            mem[AW'(item_reg.key_slot)] <= item_reg.key_time;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // The item register is loaded as the controller accepts the beat.
    logic signed [32:0] t_clamp;
    logic signed [49:0] rem_local;
    logic [33:0] sub;

    always_comb
    begin
        rem_local = local_reg;
        if (local_reg > 50'(dur_reg))
            rem_local = loop_reg ? 50'(signed'({1'b0, rem_reg[32:0]})) : 50'(dur_reg);
        t_clamp = 33'(rem_local);
        if (rem_local < 50'(first_reg))
            t_clamp = 33'(first_reg);
        else if (rem_local > 50'(last_reg))
            t_clamp = 33'(last_reg);
        sub = {rem_reg[32:0], quo_reg[49]} - den_reg;
    end

    // Interpolant numerator and span come from k and k+1 entries.
    logic signed [32:0] num_s, span_s;
    logic [16:0] frac_simple_v;
    logic simple;
    assign num_s = t_reg - 33'(kv_reg);
    assign span_s = 33'(rd_data_reg) - 33'(kv_reg);
    always_comb
    begin
        simple = 1'b1;
        frac_simple_v = '0;
        if (span_s > 0 && num_s > 0)
        begin
            if (num_s >= span_s)
                frac_simple_v = 17'd65536;
            else
                simple = 1'b0;
        end
    end

    assign cnt_ext = 8'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= CW'(n_eff);
            k_reg <= '0;
        end
        if (cmd.cap_first)
            first_reg <= rd_data_reg;
        if (cmd.cap_last)
        begin
            last_reg <= rd_data_reg;
            dur_reg  <= 33'(rd_data_reg) - 33'(first_reg);
            diff_reg <= 33'(item_reg.global_time) - 33'(start_reg);
        end
        if (cmd.mul)
            prod_reg <= 66'(rate_reg) * 66'(diff_reg);
        if (cmd.scale)
            local_reg <= 50'(prod_reg >>> 16);
        if (cmd.div_start)
        begin
            // Divide local time by duration, or the interpolant numerator by span.
            if (!cmd.span_cap)
            begin
                quo_reg <= 50'(local_reg);
                den_reg <= 34'(dur_reg);
                rem_reg <= '0;
                cnt_reg <= 6'd50;
                div_frac_reg <= 1'b0;
            end
            else
            begin
                // The numerator is below the span, so it seeds the remainder
                // and sixteen more steps give the Q0.16 fraction.
                quo_reg <= '0;
                den_reg <= 34'(span_s);
                rem_reg <= 34'(num_s);
                cnt_reg <= 6'd16;
                div_frac_reg <= 1'b1;
            end
        end
        else if (cmd.div_step)
        begin
            if (!sub[33])
            begin
                rem_reg <= sub;
                quo_reg <= {quo_reg[48:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[32:0], quo_reg[49]};
                quo_reg <= {quo_reg[48:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (cmd.wrap_done)
            t_reg <= t_clamp;
        if (cmd.srch_cmp)
        begin
            if (t_reg > 33'(rd_data_reg) && (32'(k_reg) + 2 < 32'(n_reg)))
                k_reg <= k_reg + AW'(1);
        end
        if (kv_cap_reg)
            kv_reg <= rd_data_reg;
    end

    // Key k arrives from the memory in the cycle after its read is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kv_cap_reg <= 1'b0;
        else
            kv_cap_reg <= cmd.span_rd;
    end

    logic signed [31:0] sat_local;
    always_comb
    begin
        if (rem_local > 50'sh7fffffff)
            sat_local = 32'sh7fffffff;
        else if (rem_local < -50'sh80000000)
            sat_local = 32'sh80000000;
        else
            sat_local = 32'(rem_local);
    end

    logic [16:0] frac_reg;
    logic signed [31:0] lsat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wrap_done)
            lsat_reg <= sat_local;
        if (cmd.span_cap)
            frac_reg <= frac_simple_v;
        else if (cmd.frac_done)
            frac_reg <= 17'(quo_reg[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= '0;
        else if (cmd.err_out)
            res_reg <= '{span_index: '0, interpolant: '0, local_time: '0, error: 1'b1};
        else if (cmd.wr_out)
            res_reg <= '0;
        else if (cmd.frac_done)
        begin
            res_reg.span_index  <= 6'(k_reg);
            res_reg.interpolant <= simple_hold_reg ? frac_reg : 17'(quo_reg[15:0]);
            res_reg.local_time  <= lsat_reg;
            res_reg.error       <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.span_cap)
            simple_hold_reg <= simple;
    end

    // Item register captured on load command only.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
    end

    assign res = res_reg;
    assign stat.is_write    = item_reg.opcode == OP_WRITE;
    assign stat.n_small     = n_reg < CW'(2);
    assign stat.dur_bad     = dur_reg <= 0;
    assign stat.need_wrap   = local_reg > 50'(dur_reg) && loop_reg;
    assign stat.srch_more   = (32'(k_reg) + 2 < 32'(n_reg)) && t_reg > 33'(rd_data_reg);
    assign stat.frac_simple = simple;
    assign stat.div_last    = cnt_ext == 8'd1;
    logic unused;
    assign unused = div_frac_reg ^ cnt_ext[7];
endmodule

>>> hw/rtl/kftl_ctrl.sv
// Controller state machine of the keyframe time locator.
module kftl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  kftl_pkg::stat_t stat,
    output kftl_pkg::cmd_t  cmd
);
    import kftl_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'd1,
        S_DEC   = 16'd2,
        S_CAPL  = 16'd4,
        S_MUL   = 16'd8,
        S_SCALE = 16'd16,
        S_WDIV  = 16'd32,
        S_WSTEP = 16'd64,
        S_WFIN  = 16'd128,
        S_SRD   = 16'd256,
        S_SCMP  = 16'd512,
        S_PRD   = 16'd1024,
        S_PCAP  = 16'd2048,
        S_FFIN  = 16'd4096,
        S_FSTEP = 16'd8192,
        S_FDONE = 16'd16384,
        S_OUT   = 16'd32768
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    // A new beat is taken once the previous result has left or is leaving.
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg;
        cmd = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = S_DEC;
                cmd.load = in_valid && in_ready;
            end
            S_DEC:
            begin
                if (stat.is_write)
                begin
                    cmd.wr_out = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.n_small)
                begin
                    cmd.err_out = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    // Key 0 is on the read port now; the read of the last key is issued here.
                    cmd.cap_first = 1'b1;
                    cmd.rd_last = 1'b1;
                    state_next = S_CAPL;
                end
            end
            S_CAPL:  begin cmd.cap_last = 1'b1; state_next = S_MUL; end
            S_MUL:
            begin
                if (stat.dur_bad)
                begin
                    cmd.err_out = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mul = 1'b1;
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin cmd.scale = 1'b1; state_next = S_WDIV; end
            S_WDIV:
            begin
                if (stat.need_wrap)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_WSTEP;
                end
                else
                    state_next = S_WFIN;
            end
            S_WSTEP:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_WFIN;
            end
            S_WFIN:  begin cmd.wrap_done = 1'b1; state_next = S_SRD; end
            S_SRD:   begin cmd.srch_rd = 1'b1; state_next = S_SCMP; end
            S_SCMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next = stat.srch_more ? S_SRD : S_PRD;
            end
            S_PRD:   begin cmd.span_rd = 1'b1; state_next = S_PCAP; end
            S_PCAP:
            begin
                cmd.srch_rd = 1'b1;
                state_next = S_FFIN;
            end
            S_FFIN:
            begin
                cmd.span_cap = 1'b1;
                if (stat.frac_simple)
                    state_next = S_FDONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_FSTEP;
                end
            end
            S_FSTEP:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_FDONE;
            end
            S_FDONE: begin cmd.frac_done = 1'b1; state_next = S_OUT; end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

>>> hw/rtl/kftl_checker.sv
// Port checker for the keyframe time locator and its bind.
module kftl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input kftl_pkg::out_item_t out_data,
    input logic                out_valid,
    input logic                out_ready
);
    import kftl_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.span_index == 6'd0
            && out_data.interpolant == 17'd0 && out_data.local_time == 32'sd0)
        else $error("error result not cleared");

    a_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.interpolant <= 17'd65536)
        else $error("interpolant out of range");
endmodule

bind keyframe_time_locate kftl_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
